/* hw/rtl/dqs_pkg.sv */
`default_nettype none

package dqs_pkg;

	localparam int DEPTH_DEF = 64;
	localparam int MODE_W    = 3;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 6;
	localparam int COUNT_W   = 7;

	typedef enum logic [MODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SEARCH     = 3'd4
	} dqs_op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE      = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} dqs_status_t;

	typedef struct packed {
		logic        take_in;
		logic        push;
		logic        rd_start;
		logic        rd_next;
		logic        pop_commit;
		logic        cmp_clr;
		logic        cmp_inc;
		logic        res_we;
		dqs_status_t res_code;
		logic        res_pop;
		logic        res_pos;
		logic        out_load;
	} dqs_cmd_t;

	typedef struct packed {
		dqs_op_t op;
		logic    full;
		logic    empty;
		logic    match;
		logic    last;
		logic    out_free;
	} dqs_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/dqs_ram.sv */
`default_nettype none

module dqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/dqs_ctrl.sv */
`default_nettype none

module dqs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire dqs_pkg::dqs_stat_t stat,
	output dqs_pkg::dqs_cmd_t       cmd
);

	import dqs_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_TAKE,
		S_SEARCH,
		S_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd      = '0;
		cmd.res_code = STAT_DONE;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d    = S_FINISH;
				cmd.res_we = 1'b1;
				unique case (stat.op)
					OP_PUSH_FRONT, OP_PUSH_BACK: begin
						if (stat.full) begin
							cmd.res_code = STAT_FULL;
						end else begin
							cmd.push = 1'b1;
						end
					end
					OP_POP_FRONT, OP_POP_BACK: begin
						if (stat.empty) begin
							cmd.res_code = STAT_EMPTY;
						end else begin
							cmd.res_we   = 1'b0;
							cmd.rd_start = 1'b1;
							state_d      = S_POP_TAKE;
						end
					end
					OP_SEARCH: begin
						if (stat.empty) begin
							cmd.res_code = STAT_NOT_FOUND;
						end else begin
							cmd.res_we   = 1'b0;
							cmd.rd_start = 1'b1;
							cmd.cmp_clr  = 1'b1;
							state_d      = S_SEARCH;
						end
					end
					default: begin
					end
				endcase
			end
			S_POP_TAKE: begin
				cmd.pop_commit = 1'b1;
				cmd.res_we     = 1'b1;
				cmd.res_pop    = 1'b1;
				state_d        = S_FINISH;
			end
			S_SEARCH: begin
				priority if (stat.match) begin
					cmd.res_we  = 1'b1;
					cmd.res_pos = 1'b1;
					state_d     = S_FINISH;
				end else if (stat.last) begin
					cmd.res_we   = 1'b1;
					cmd.res_code = STAT_NOT_FOUND;
					state_d      = S_FINISH;
				end else begin
					cmd.rd_next = 1'b1;
					cmd.cmp_inc = 1'b1;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/dqs_dp.sv */
`default_nettype none

module dqs_dp #(
	parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic        [dqs_pkg::MODE_W-1:0]     mode,
	input  wire logic signed [dqs_pkg::VALUE_W-1:0]    value,
	input  wire logic                                  out_stall,
	output logic                                       out_valid,
	output logic             [dqs_pkg::STATUS_W-1:0]   status,
	output logic signed      [dqs_pkg::VALUE_W-1:0]    popped_value,
	output logic             [dqs_pkg::POS_W-1:0]      found_position,
	output logic             [dqs_pkg::COUNT_W-1:0]    entry_count,
	input  wire dqs_pkg::dqs_cmd_t                     cmd,
	output dqs_pkg::dqs_stat_t                         stat
);

	import dqs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	dqs_op_t                   op_q;
	logic signed [VALUE_W-1:0] value_q;
	logic        [AW-1:0]      front_q;
	logic        [CW-1:0]      count_q;
	logic        [AW-1:0]      cmp_q;

	dqs_status_t               res_status_q;
	logic signed [VALUE_W-1:0] res_pop_q;
	logic        [AW-1:0]      res_pos_q;

	logic                      out_valid_q;
	logic [STATUS_W-1:0]       status_q;
	logic signed [VALUE_W-1:0] popped_q;
	logic [POS_W-1:0]          pos_q;
	logic [COUNT_W-1:0]        cnt_out_q;

	logic [AW-1:0]      front_dec;
	logic [AW-1:0]      front_inc;
	logic [CW-1:0]      cnt_m1;
	logic [AW-1:0]      back_wr_addr;
	logic [AW-1:0]      back_rd_addr;
	logic [AW-1:0]      next_rd_addr;
	logic [AW-1:0]      start_addr;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic [VALUE_W-1:0] rdata;
	logic               out_free;
	logic [AW+5:0]      pos_wide;
	logic [CW+6:0]      cnt_wide;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
		input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign front_dec    = (front_q == '0) ? AW'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc    = (front_q == AW'(DEPTH - 1)) ? '0 : front_q + 1'b1;
	assign cnt_m1       = count_q - 1'b1;
	assign back_wr_addr = wrap_add(front_q, count_q[AW-1:0]);
	assign back_rd_addr = wrap_add(front_q, cnt_m1[AW-1:0]);
	assign next_rd_addr = wrap_add(front_q, cmp_q + 1'b1);
	assign start_addr   = (op_q == OP_POP_BACK) ? back_rd_addr : front_q;
	assign raddr        = cmd.rd_next ? next_rd_addr : start_addr;
	assign waddr        = (op_q == OP_PUSH_FRONT) ? front_dec : back_wr_addr;

	dqs_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(waddr),
		.wdata(value_q),
		.re   (cmd.rd_start | cmd.rd_next),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		stat          = '0;
		stat.op       = op_q;
		stat.full     = (count_q == CW'(DEPTH));
		stat.empty    = (count_q == '0);
		stat.match    = (rdata == value_q);
		stat.last     = (cmp_q == cnt_m1[AW-1:0]);
		stat.out_free = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			op_q    <= dqs_op_t'(mode);
			value_q <= value;
		end
		if (cmd.cmp_clr) begin
			cmp_q <= '0;
		end else if (cmd.cmp_inc) begin
			cmp_q <= cmp_q + 1'b1;
		end
		if (cmd.res_we) begin
			res_status_q <= cmd.res_code;
			res_pop_q    <= cmd.res_pop ? rdata : '0;
			res_pos_q    <= cmd.res_pos ? cmp_q : '0;
		end
		if (cmd.out_load) begin
			status_q  <= res_status_q;
			popped_q  <= res_pop_q;
			pos_q     <= pos_wide[POS_W-1:0];
			cnt_out_q <= cnt_wide[COUNT_W-1:0];
		end
	end

	assign pos_wide = (AW+6)'(res_pos_q);
	assign cnt_wide = (CW+7)'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.push) begin
				count_q <= count_q + 1'b1;
				if (op_q == OP_PUSH_FRONT) begin
					front_q <= front_dec;
				end
			end else if (cmd.pop_commit) begin
				count_q <= cnt_m1;
				if (op_q == OP_POP_FRONT) begin
					front_q <= front_inc;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign popped_value   = popped_q;
	assign found_position = pos_q;
	assign entry_count    = cnt_out_q;

endmodule

`default_nettype wire

/* hw/rtl/deque_with_search_top.sv */
// Double-ended queue of signed 32-bit values with a linear search.
// Input channel (in_valid/in_stall, mode/value): one transaction is one
// operation: push front, push back, pop front, pop back or search.
// Output channel (out_valid/out_stall): exactly one result transaction per
// operation with status, popped_value, found_position and entry_count.
// Items are handled one at a time by a controller and a datapath around a
// single-port-read store of DEPTH words with registered read data.
// Pushes, unused modes, and pops or searches on an empty queue finish
// without reading the store; a pop reads the store once before it
// commits; a search reads entries from the front, one store read per
// compared entry, up to the match at front-based position k (or up to
// position held_count - 1 when nothing matches).
// A new transaction is accepted once the previous result has moved into
// the output register, so input and output are decoupled by one result.
// While out_stall is high the result holds steady; the next item is still
// processed up to its result and then waits for the output register.
// Reset empties the queue (front and count cleared); store contents are
// not cleared and are only ever read after being written.
`default_nettype none

module deque_with_search_top #(
	parameter int DEPTH = dqs_pkg::DEPTH_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic        [dqs_pkg::MODE_W-1:0]   mode,
	input  wire logic signed [dqs_pkg::VALUE_W-1:0]  value,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic             [dqs_pkg::STATUS_W-1:0] status,
	output logic signed      [dqs_pkg::VALUE_W-1:0]  popped_value,
	output logic             [dqs_pkg::POS_W-1:0]    found_position,
	output logic             [dqs_pkg::COUNT_W-1:0]  entry_count
);

	import dqs_pkg::*;

	dqs_cmd_t  cmd;
	dqs_stat_t stat;

	dqs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	dqs_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (mode),
		.value         (value),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.popped_value  (popped_value),
		.found_position(found_position),
		.entry_count   (entry_count),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import dqs_pkg::*;

	localparam logic [MODE_W-1:0] FIRST_SPARE_MODE = MODE_W'(OP_SEARCH + 1);
	localparam logic [MODE_W-1:0] LAST_SPARE_MODE  = {MODE_W{1'b1}};
	localparam int RANDOM_OPS   = 400;
	localparam int CALM_FROM    = 340;
	localparam int PRESSURE_AT  = 180;
	localparam int HOLD_CYCLES  = 120;

	typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

	typedef struct packed {
		dqs_status_t                status;
		logic signed [VALUE_W-1:0]  popped;
		logic        [POS_W-1:0]    pos;
		logic        [COUNT_W-1:0]  count;
	} op_result_t;

	class deque_mirror;
		logic [VALUE_W-1:0] held[$];
		op_result_t         pending_results[$];
		int unsigned        errors, n_full, n_empty, n_hit, n_miss, peak;

		function void apply_op(logic [MODE_W-1:0] m, logic [VALUE_W-1:0] v);
			op_result_t e;
			e = '0;
			e.status = STAT_DONE;
			case (m)
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					if (held.size() >= DEPTH_DEF) begin
						e.status = STAT_FULL;
						n_full++;
					end else if (m == OP_PUSH_FRONT)
						held.push_front(v);
					else
						held.push_back(v);
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					if (held.size() == 0) begin
						e.status = STAT_EMPTY;
						n_empty++;
					end else if (m == OP_POP_FRONT)
						e.popped = held.pop_front();
					else
						e.popped = held.pop_back();
				end
				OP_SEARCH: begin
					e.status = STAT_NOT_FOUND;
					for (int i = 0; i < held.size(); i++) begin
						if (held[i] == v) begin
							e.status = STAT_DONE;
							e.pos = POS_W'(i);
							break;
						end
					end
					if (e.status == STAT_DONE)
						n_hit++;
					else
						n_miss++;
				end
				default: ;
			endcase
			e.count = COUNT_W'(held.size());
			if (held.size() > peak)
				peak = held.size();
			pending_results.push_back(e);
		endfunction

		function void compare_result(logic [STATUS_W-1:0] st, logic signed [VALUE_W-1:0] pv,
			logic [POS_W-1:0] fp, logic [COUNT_W-1:0] ec);
			op_result_t e;
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, status %0d count %0d", $time, st, ec);
				return;
			end
			e = pending_results.pop_front();
			if (st !== e.status) begin
				errors++;
				$display("%0t: status expected %0d, actual %0d", $time, e.status, st);
			end
			if (pv !== e.popped) begin
				errors++;
				$display("%0t: popped_value expected %0d, actual %0d", $time, e.popped, pv);
			end
			if (fp !== e.pos) begin
				errors++;
				$display("%0t: found_position expected %0d, actual %0d", $time, e.pos, fp);
			end
			if (ec !== e.count) begin
				errors++;
				$display("%0t: entry_count expected %0d, actual %0d", $time, e.count, ec);
			end
		endfunction

		function logic [VALUE_W-1:0] pick_held();
			if (held.size() == 0)
				return $urandom;
			return held[$urandom_range(0, held.size() - 1)];
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_stall;
	logic        [MODE_W-1:0]    mode;
	logic signed [VALUE_W-1:0]   value;
	logic                        out_valid;
	logic                        out_stall;
	logic        [STATUS_W-1:0]  status;
	logic signed [VALUE_W-1:0]   popped_value;
	logic        [POS_W-1:0]     found_position;
	logic        [COUNT_W-1:0]   entry_count;

	deque_mirror mirror;
	bit          idle_tx, idle_rx, hold_rx;
	int unsigned n_mode[8];

	deque_with_search_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.popped_value   (popped_value),
		.found_position (found_position),
		.entry_count    (entry_count)
	);

	always #2 clk = ~clk;

	initial begin
		#2_000_000;
		$display("Some tests failed");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			mirror.compare_result(status, popped_value, found_position, entry_count);
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				hold_rx = 1'b0;
			end else if (idle_rx && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_op(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v);
		if (idle_tx && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			mode <= $urandom;
			value <= $urandom;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		mode <= m;
		value <= v;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		mirror.apply_op(m, v);
		n_mode[m]++;
	endtask

	function automatic logic [VALUE_W-1:0] rand_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return $urandom_range(0, 15) - 8;
		if (r == 3) begin
			case ($urandom_range(0, 3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return '1;
				default: return '0;
			endcase
		end
		return $urandom;
	endfunction

	// returns 1 when the transaction is a real operation, not a spare mode
	task automatic random_op(input phase_t ph, output bit real_op);
		int                 r, t_push, t_search, t_pop;
		logic [MODE_W-1:0]  m;
		logic [VALUE_W-1:0] v;
		case (ph)
			PH_FILL:  begin t_push = 70; t_search = 85; t_pop = 95; end
			PH_DRAIN: begin t_push = 10; t_search = 25; t_pop = 95; end
			default:  begin t_push = 35; t_search = 65; t_pop = 95; end
		endcase
		r = $urandom_range(0, 99);
		real_op = 1'b1;
		if (r < t_push) begin
			m = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
			v = rand_value();
		end else if (r < t_search) begin
			m = OP_SEARCH;
			v = ($urandom_range(0, 9) < 7) ? mirror.pick_held() : rand_value();
		end else if (r < t_pop) begin
			m = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
			v = $urandom;
		end else begin
			m = MODE_W'($urandom_range(FIRST_SPARE_MODE, LAST_SPARE_MODE));
			v = $urandom;
			real_op = 1'b0;
		end
		send_op(m, v);
	endtask

	initial begin
		int unsigned counted;
		int          phase_len;
		bit          real_op, pressure_done, saved_idle;
		phase_t      ph;

		in_valid <= 1'b0;
		mode <= OP_PUSH_FRONT;
		value <= '0;
		arst_n <= 1'b0;
		mirror = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty store, spare modes, field extremes, duplicates, both ends
		send_op(OP_POP_FRONT, 32'h1234_5678);
		send_op(OP_POP_BACK, '1);
		send_op(OP_SEARCH, '0);
		for (int m = FIRST_SPARE_MODE; m <= LAST_SPARE_MODE; m++)
			send_op(MODE_W'(m), $urandom);
		send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
		send_op(OP_PUSH_BACK, 32'h8000_0000);
		send_op(OP_PUSH_FRONT, '1);
		send_op(OP_PUSH_BACK, '0);
		send_op(OP_PUSH_BACK, 32'd1);
		send_op(OP_SEARCH, 32'h8000_0000);
		send_op(OP_SEARCH, 32'd1);
		send_op(OP_SEARCH, '1);
		send_op(OP_SEARCH, 32'd12345);
		send_op(OP_PUSH_FRONT, 32'h8000_0000);
		send_op(OP_SEARCH, 32'h8000_0000);
		send_op(OP_POP_BACK, '0);
		send_op(OP_POP_FRONT, '0);
		send_op(OP_POP_FRONT, '1);
		send_op(OP_POP_BACK, '0);
		send_op(OP_POP_BACK, '1);
		send_op(OP_POP_FRONT, '0);
		send_op(OP_POP_FRONT, '0);

		counted = 0;
		pressure_done = 1'b0;
		while (counted < RANDOM_OPS) begin
			if (counted == 0) begin
				ph = PH_FILL;
				phase_len = 90;
			end else begin
				ph = phase_t'($urandom_range(0, 2));
				phase_len = $urandom_range(20, 70);
			end
			idle_tx = $urandom_range(0, 2) != 0;
			idle_rx = $urandom_range(0, 2) != 0;
			if (!pressure_done && counted >= PRESSURE_AT) begin
				// long output hold while the sender keeps offering
				pressure_done = 1'b1;
				saved_idle = idle_tx;
				idle_tx = 1'b0;
				hold_rx = 1'b1;
				repeat (24) begin
					random_op(PH_FILL, real_op);
					if (real_op)
						counted++;
				end
				idle_tx = saved_idle;
			end
			repeat (phase_len) begin
				if (counted >= CALM_FROM) begin
					idle_tx = 1'b0;
					idle_rx = 1'b0;
				end
				random_op(ph, real_op);
				if (real_op)
					counted++;
			end
		end
		in_valid <= 1'b0;

		while (mirror.pending() != 0)
			@(posedge clk);
		repeat (DEPTH_DEF + 8) @(posedge clk);

		$display("Ran %0d push front, %0d push back, %0d pop front, %0d pop back, %0d search",
			n_mode[OP_PUSH_FRONT], n_mode[OP_PUSH_BACK], n_mode[OP_POP_FRONT],
			n_mode[OP_POP_BACK], n_mode[OP_SEARCH]);
		$display("Saw %0d full pushes, %0d empty pops, %0d hits, %0d misses, peak depth %0d",
			mirror.n_full, mirror.n_empty, mirror.n_hit, mirror.n_miss, mirror.peak);
		if (mirror.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* files.f */
hw/rtl/dqs_pkg.sv
hw/rtl/dqs_ram.sv
hw/rtl/dqs_ctrl.sv
hw/rtl/dqs_dp.sv
hw/rtl/deque_with_search_top.sv
tb/testbench.sv
